>>> rtl/core/assert_macros.svh
// Assertion macros used by the top level of the frame rate quality governor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define FRQG_ASSERT_IMPLIES(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("frqg assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define FRQG_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("frqg assertion failed");

`endif

>>> rtl/core/frqg_pkg.sv
// Types and constants shared by the frame rate quality governor modules.
`default_nettype none

package frqg_pkg;

   // Shared divider widths: dividend covers 256e6 and any window sum.
   localparam int DIVIDEND_W = 28;
   localparam int DIVISOR_W  = 20;

   // One million in 8.8 fixed point.
   localparam logic [DIVIDEND_W-1:0] RATE_SCALE = 28'd256000000;

   // Operation codes.
   localparam logic [1:0] OP_FRAME     = 2'd0;
   localparam logic [1:0] OP_SET_LEVEL = 2'd1;
   localparam logic [1:0] OP_MEM_CHECK = 2'd2;

   // Configuration register indexes.
   localparam logic [2:0] CSR_AUTO_SCALE = 3'd0;
   localparam logic [2:0] CSR_RATE_MAINT = 3'd1;
   localparam logic [2:0] CSR_MEM_MGMT   = 3'd2;
   localparam logic [2:0] CSR_TARGET_FPS = 3'd3;
   localparam logic [2:0] CSR_MEM_WARN   = 3'd4;
   localparam logic [2:0] CSR_MEM_CRIT   = 3'd5;

   // Quality levels.
   localparam logic [1:0] LEVEL_LOW   = 2'd0;
   localparam logic [1:0] LEVEL_HIGH  = 2'd2;
   localparam logic [1:0] LEVEL_ULTRA = 2'd3;

   localparam logic [7:0] RUN_MAX = 8'd255;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

>>> rtl/core/frame_rate_quality_governor.sv
// Top level of the frame rate quality governor: sequencer, window store and level control.
`default_nettype none
`include "assert_macros.svh"

// The governor takes one item at a time. A frame item with a nonzero frame time runs
// two divisions through one shared restoring divider of 28 steps each: first the rate
// sample, 256000000 / frame time saturated to 65535 in 8.8 fixed point, and then the
// window average, sum / count. A frame item without a time sample, a set-level item,
// a memory check and the unused code bypass the divider. The block stalls its input
// while an item is in work, but it can start a new item while the previous result
// still waits in the output register; that item then waits in its final step for as
// long as the receiver holds the earlier result. The rate window is a small memory of
// WINDOW entries; values read from it are only used once the window is full, so it
// needs no clearing pass after reset. Configuration writes are to be made only while
// idle.
module frame_rate_quality_governor #(
   parameter int WINDOW      = 60,
   parameter int DOWN_FRAMES = 30,
   parameter int UP_FRAMES   = 180,
   parameter int MEM_PERIOD  = 60
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Configuration port
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata,
   // Input items
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_op,
   input  wire logic [19:0] req_frame_time_us,
   input  wire logic [15:0] req_mem_usage_mb,
   input  wire logic [1:0]  req_new_level,
   // Result items
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_quality_level,
   output logic             rsp_level_changed,
   output logic             rsp_memory_warning,
   output logic             rsp_memory_critical,
   output logic [15:0]      rsp_current_fps,
   output logic [15:0]      rsp_average_fps
);
   import frqg_pkg::*;

   localparam int SUM_W = 16 + $clog2(WINDOW);
   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int PER_W = $clog2(MEM_PERIOD + 1);

   // Sequencer states.
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_RDIV  = 3'd1;
   localparam logic [2:0] S_UPD   = 3'd2;
   localparam logic [2:0] S_AVG   = 3'd3;
   localparam logic [2:0] S_ADIV  = 3'd4;
   localparam logic [2:0] S_CHECK = 3'd5;
   localparam logic [2:0] S_FIN   = 3'd6;

   // Configuration registers.
   logic        auto_en_ff, rate_en_ff, mem_en_ff;
   logic [7:0]  target_ff;
   logic [15:0] warn_mb_ff, crit_mb_ff;

   // Sequencer and item registers.
   logic [2:0]  state_ff, state_in;
   logic [1:0]  op_ff, op_in;
   logic [15:0] mb_ff, mb_in;
   logic [1:0]  nl_ff, nl_in;
   logic [1:0]  before_ff, before_in;

   // Governor state.
   logic [SUM_W-1:0] win_sum_ff, win_sum_in;
   logic [CNT_W-1:0] win_cnt_ff, win_cnt_in;
   logic [PTR_W-1:0] win_ptr_ff, win_ptr_in;
   logic [15:0]      last_fps_ff, last_fps_in;
   logic [15:0]      avg_ff, avg_in;
   logic [7:0]       low_run_ff, low_run_in;
   logic [7:0]       good_run_ff, good_run_in;
   logic [1:0]       level_ff, level_in;
   logic [PER_W-1:0] period_ff, period_in;
   logic             warn_ff, warn_in;
   logic             crit_ff, crit_in;

   // Output register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_load;
   logic [1:0]  rsp_level_ff;
   logic        rsp_changed_ff, rsp_warn_ff, rsp_crit_ff;
   logic [15:0] rsp_cur_ff, rsp_avg_ff;

   // Window store.
   logic [15:0] win_mem [WINDOW];
   logic [15:0] win_rd_ff;
   logic        win_we;
   logic        win_full;

   // Shared divider.
   div_req_type div_req;
   div_rsp_type div_rsp;

   // Rate check and memory check terms.
   logic [19:0]      avg10, tgt9, tgt12;
   logic             is_low, is_good;
   logic [7:0]       low_inc, good_inc;
   logic             do_mem;
   logic             accept;
   logic [PER_W-1:0] period_inc;

   frqg_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         auto_en_ff <= 1'b1;
         rate_en_ff <= 1'b1;
         mem_en_ff  <= 1'b1;
         target_ff  <= 8'd60;
         warn_mb_ff <= 16'd512;
         crit_mb_ff <= 16'd1024;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_AUTO_SCALE: auto_en_ff <= csr_wdata[0];
            CSR_RATE_MAINT: rate_en_ff <= csr_wdata[0];
            CSR_MEM_MGMT:   mem_en_ff  <= csr_wdata[0];
            CSR_TARGET_FPS: target_ff  <= csr_wdata[7:0];
            CSR_MEM_WARN:   warn_mb_ff <= csr_wdata;
            CSR_MEM_CRIT:   crit_mb_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign win_full  = (win_cnt_ff == CNT_W'(WINDOW));
   assign win_we    = (state_ff == S_UPD);

   // The read of the oldest entry is only used once the window is full.
   always_ff @(posedge clock) begin
      if (win_we) begin
         win_mem[win_ptr_ff] <= last_fps_ff;
      end
      win_rd_ff <= win_mem[win_ptr_ff];
   end

   // Rate comparison against 0.9 and 1.2 of the target, all scaled by ten.
   assign avg10   = {1'b0, avg_ff, 3'b000} + {3'b000, avg_ff, 1'b0};
   assign tgt9    = 20'({target_ff, 8'd0}) * 20'd9;
   assign tgt12   = 20'({target_ff, 8'd0}) * 20'd12;
   assign is_low  = (avg10 < tgt9);
   assign is_good = !is_low && (avg10 > tgt12);
   assign low_inc  = (low_run_ff == RUN_MAX) ? RUN_MAX : low_run_ff + 8'd1;
   assign good_inc = (good_run_ff == RUN_MAX) ? RUN_MAX : good_run_ff + 8'd1;
   assign period_inc = period_ff + 1'b1;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      mb_in        = mb_ff;
      nl_in        = nl_ff;
      before_in    = before_ff;
      win_sum_in   = win_sum_ff;
      win_cnt_in   = win_cnt_ff;
      win_ptr_in   = win_ptr_ff;
      last_fps_in  = last_fps_ff;
      avg_in       = avg_ff;
      low_run_in   = low_run_ff;
      good_run_in  = good_run_ff;
      level_in     = level_ff;
      period_in    = period_ff;
      warn_in      = warn_ff;
      crit_in      = crit_ff;
      do_mem       = 1'b0;
      rsp_load     = 1'b0;
      div_req      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in     = req_op;
               mb_in     = req_mem_usage_mb;
               nl_in     = req_new_level;
               before_in = level_ff;
               if ((req_op == OP_FRAME) && (req_frame_time_us != '0)) begin
                  div_req.start    = 1'b1;
                  div_req.dividend = RATE_SCALE;
                  div_req.divisor  = req_frame_time_us;
                  state_in         = S_RDIV;
               end else begin
                  state_in = S_CHECK;
               end
            end
         end
         S_RDIV: begin
            if (div_rsp.done) begin
               if (div_rsp.quotient[DIVIDEND_W-1:16] != '0) begin
                  last_fps_in = 16'hFFFF;
               end else begin
                  last_fps_in = div_rsp.quotient[15:0];
               end
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            // Drop the oldest sample once full, then add the new one.
            if (win_full) begin
               win_sum_in = win_sum_ff - SUM_W'(win_rd_ff) + SUM_W'(last_fps_ff);
            end else begin
               win_sum_in = win_sum_ff + SUM_W'(last_fps_ff);
               win_cnt_in = win_cnt_ff + 1'b1;
            end
            if (win_ptr_ff == PTR_W'(WINDOW - 1)) begin
               win_ptr_in = '0;
            end else begin
               win_ptr_in = win_ptr_ff + 1'b1;
            end
            state_in = S_AVG;
         end
         S_AVG: begin
            div_req.start    = 1'b1;
            div_req.dividend = DIVIDEND_W'(win_sum_ff);
            div_req.divisor  = DIVISOR_W'(win_cnt_ff);
            state_in         = S_ADIV;
         end
         S_ADIV: begin
            if (div_rsp.done) begin
               avg_in   = div_rsp.quotient[15:0];
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            priority if (op_ff == OP_FRAME) begin
               if (rate_en_ff && auto_en_ff) begin
                  priority if (is_low) begin
                     good_run_in = '0;
                     if ((low_inc >= 8'(DOWN_FRAMES)) && (level_ff != LEVEL_LOW)) begin
                        level_in   = level_ff - 2'd1;
                        low_run_in = '0;
                     end else begin
                        low_run_in = low_inc;
                     end
                  end else if (is_good) begin
                     low_run_in = '0;
                     if ((good_inc >= 8'(UP_FRAMES)) && (level_ff != LEVEL_ULTRA)) begin
                        level_in    = level_ff + 2'd1;
                        good_run_in = '0;
                     end else begin
                        good_run_in = good_inc;
                     end
                  end else begin
                     low_run_in  = '0;
                     good_run_in = '0;
                  end
               end
               if (period_inc >= PER_W'(MEM_PERIOD)) begin
                  period_in = '0;
                  do_mem    = 1'b1;
               end else begin
                  period_in = period_inc;
               end
            end else if (op_ff == OP_SET_LEVEL) begin
               level_in    = nl_ff;
               low_run_in  = '0;
               good_run_in = '0;
            end else if (op_ff == OP_MEM_CHECK) begin
               do_mem = 1'b1;
            end else begin
               do_mem = 1'b0;
            end
            // The critical test wins over the warning test.
            if (do_mem && mem_en_ff) begin
               priority if (mb_ff >= crit_mb_ff) begin
                  warn_in  = 1'b1;
                  crit_in  = 1'b1;
                  level_in = LEVEL_LOW;
               end else if (mb_ff >= warn_mb_ff) begin
                  warn_in = 1'b1;
                  crit_in = 1'b0;
               end else begin
                  warn_in = 1'b0;
                  crit_in = 1'b0;
               end
            end
            state_in = S_FIN;
         end
         S_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         win_sum_ff   <= '0;
         win_cnt_ff   <= '0;
         win_ptr_ff   <= '0;
         last_fps_ff  <= '0;
         avg_ff       <= '0;
         low_run_ff   <= '0;
         good_run_ff  <= '0;
         level_ff     <= LEVEL_HIGH;
         period_ff    <= '0;
         warn_ff      <= 1'b0;
         crit_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         win_sum_ff   <= win_sum_in;
         win_cnt_ff   <= win_cnt_in;
         win_ptr_ff   <= win_ptr_in;
         last_fps_ff  <= last_fps_in;
         avg_ff       <= avg_in;
         low_run_ff   <= low_run_in;
         good_run_ff  <= good_run_in;
         level_ff     <= level_in;
         period_ff    <= period_in;
         warn_ff      <= warn_in;
         crit_ff      <= crit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      mb_ff     <= mb_in;
      nl_ff     <= nl_in;
      before_ff <= before_in;
      if (rsp_load) begin
         rsp_level_ff   <= level_ff;
         rsp_changed_ff <= (level_ff != before_ff);
         rsp_warn_ff    <= warn_ff;
         rsp_crit_ff    <= crit_ff;
         rsp_cur_ff     <= last_fps_ff;
         rsp_avg_ff     <= avg_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_quality_level   = rsp_level_ff;
   assign rsp_level_changed   = rsp_changed_ff;
   assign rsp_memory_warning  = rsp_warn_ff;
   assign rsp_memory_critical = rsp_crit_ff;
   assign rsp_current_fps     = rsp_cur_ff;
   assign rsp_average_fps     = rsp_avg_ff;

   `FRQG_ASSERT_IMPLIES(a_div_done, div_rsp.done, state_ff == S_RDIV || state_ff == S_ADIV)
   `FRQG_ASSERT_IMPLIES(a_ptr_tracks_count, !win_full, CNT_W'(win_ptr_ff) == win_cnt_ff)
   `FRQG_ASSERT_IMPLIES(a_rsp_from_fin, $rose(rsp_valid_ff), $past(state_ff) == S_FIN)
   `FRQG_ASSERT_NEXT(a_avg_then_check, (state_ff == S_ADIV) && div_rsp.done, state_ff == S_CHECK)

endmodule

`default_nettype wire

>>> rtl/core/frqg_div.sv
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module frqg_div (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire frqg_pkg::div_req_type div_req,
   output frqg_pkg::div_rsp_type    div_rsp
);
   import frqg_pkg::*;

   localparam int STEP_W = $clog2(DIVIDEND_W);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [DIVIDEND_W-1:0] dvd_ff, dvd_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   // Bring down the next dividend bit and try the subtraction.
   assign trial = {rem_ff, dvd_ff[DIVIDEND_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = (trial >= {1'b0, dvs_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         dvd_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
         rem_in  = '0;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         quo_in  = {quo_ff[DIVIDEND_W-2:0], fits};
         dvd_in  = {dvd_ff[DIVIDEND_W-2:0], 1'b0};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      dvd_ff  <= dvd_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
      rem_ff  <= rem_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

`default_nettype wire

>>> verif/frame_rate_quality_governor_tb.sv
// Self-checking testbench for the frame rate quality governor: directed probes, then random items.
`timescale 1ns / 100ps

// The testbench drives items into the governor over the valid/stall input channel and
// collects results on the output channel. Every accepted item is run through a local
// predictor of the governor, which keeps its own rate window, run counters, level and
// memory flags. The expected status is queued, and each accepted result is compared
// field by field with the oldest expected status. Inputs change on the falling clock
// edge and everything is sampled on the rising edge.
module frame_rate_quality_governor_tb;
   import frqg_pkg::*;

   // Depth and thresholds of the governor as built with its default parameters.
   localparam int unsigned WINDOW      = 60;
   localparam int unsigned DOWN_FRAMES = 30;
   localparam int unsigned UP_FRAMES   = 180;
   localparam int unsigned MEM_PERIOD  = 60;
   localparam int unsigned RUN_CAP     = 255;
   localparam int unsigned FPS_DIVIDEND = 256000000;

   // The code that the governor ignores, and the level that the package does not name.
   localparam logic [1:0] OP_UNUSED    = 2'd3;
   localparam logic [1:0] LEVEL_MEDIUM = 2'd1;

   // The settling pause covers the work of the longest item, a frame item with a time
   // sample. The watchdog allows for long receiver stalls and the pauses between
   // phases.
   localparam int SETTLE_CYCLES = 80;
   localparam int QUIET_LIMIT   = 3000;

   typedef struct packed {
      logic [1:0]  level;
      logic        changed;
      logic        warn;
      logic        crit;
      logic [15:0] fps;
      logic [15:0] avg_fps;
   } governor_status_type;

   // One directed probe. Where typed is set, the status is known at a glance and is
   // checked as written; otherwise the predictor supplies it.
   typedef struct packed {
      logic [1:0]          op;
      logic [19:0]         ft;
      logic [15:0]         mb;
      logic [1:0]          nl;
      logic                typed;
      governor_status_type want;
   } probe_row_type;

   // Register settings for one random phase, with its item count and its share of noise.
   typedef struct packed {
      logic        en_scale;
      logic        en_rate;
      logic        en_mem;
      logic [7:0]  target;
      logic [15:0] warn;
      logic [15:0] crit;
      int unsigned items;
      int unsigned noise_pct;
   } phase_row_type;

   // How the frame times of a run of frame items are drawn.
   typedef enum logic [1:0] {PACE_SLOW, PACE_FAST, PACE_WIDE, PACE_NEAR} frame_pace_type;

   localparam int PROBE_COUNT = 21;
   localparam probe_row_type PROBES [PROBE_COUNT] = '{
      // The unused code straight after reset reports the reset status.
      '{OP_UNUSED, 20'd0, 16'd0, 2'd0, 1'b1,
        '{LEVEL_HIGH, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0}},
      // A frame without a time sample leaves the window empty.
      '{OP_FRAME, 20'd0, 16'd0, 2'd0, 1'b1,
        '{LEVEL_HIGH, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0}},
      // The shortest frame time saturates the rate.
      '{OP_FRAME, 20'd1, 16'hFFFF, 2'd0, 1'b1,
        '{LEVEL_HIGH, 1'b0, 1'b0, 1'b0, 16'd65535, 16'd65535}},
      // The longest frame time gives the smallest rate.
      '{OP_FRAME, 20'hFFFFF, 16'd0, 2'd0, 1'b1,
        '{LEVEL_HIGH, 1'b0, 1'b0, 1'b0, 16'd244, 16'd32889}},
      // Either side of the saturation point of the rate.
      '{OP_FRAME, 20'd3906, 16'd0, 2'd0, 1'b0, '0},
      '{OP_FRAME, 20'd3907, 16'd0, 2'd0, 1'b0, '0},
      // Direct level writes, one of them leaving the level as it is.
      '{OP_SET_LEVEL, 20'd0, 16'd0, LEVEL_ULTRA, 1'b0, '0},
      '{OP_SET_LEVEL, 20'd0, 16'd0, LEVEL_ULTRA, 1'b0, '0},
      '{OP_SET_LEVEL, 20'hFFFFF, 16'hFFFF, LEVEL_LOW, 1'b0, '0},
      '{OP_SET_LEVEL, 20'd0, 16'd0, LEVEL_MEDIUM, 1'b0, '0},
      // Memory checks on and around the reset thresholds.
      '{OP_MEM_CHECK, 20'd0, 16'd511, 2'd0, 1'b0, '0},
      '{OP_MEM_CHECK, 20'd0, 16'd512, 2'd0, 1'b0, '0},
      '{OP_MEM_CHECK, 20'd0, 16'd1023, 2'd0, 1'b0, '0},
      '{OP_MEM_CHECK, 20'd0, 16'd1024, 2'd0, 1'b0, '0},
      '{OP_MEM_CHECK, 20'hFFFFF, 16'hFFFF, 2'd3, 1'b0, '0},
      '{OP_MEM_CHECK, 20'd0, 16'd0, 2'd0, 1'b0, '0},
      // The unused code with every payload bit set.
      '{OP_UNUSED, 20'hFFFFF, 16'hFFFF, 2'd3, 1'b0, '0},
      '{OP_FRAME, 20'd0, 16'hFFFF, 2'd3, 1'b0, '0},
      '{OP_SET_LEVEL, 20'd0, 16'd0, LEVEL_HIGH, 1'b0, '0},
      '{OP_FRAME, 20'd2, 16'd1024, 2'd0, 1'b0, '0},
      '{OP_FRAME, 20'd524288, 16'd0, 2'd0, 1'b0, '0}
   };

   // The phases run through the extremes of every register: both values of each enable,
   // the smallest and largest target and a zero target, thresholds at both ends, and a
   // critical threshold below the warning one.
   localparam int PHASE_COUNT = 6;
   localparam phase_row_type PHASES [PHASE_COUNT] = '{
      '{1'b1, 1'b1, 1'b1, 8'd60,  16'd512,   16'd1024,  40,  30},
      '{1'b1, 1'b1, 1'b1, 8'd1,   16'd40000, 16'd60000, 180, 5},
      '{1'b0, 1'b1, 1'b1, 8'd255, 16'hFFFF,  16'd0,     30,  40},
      '{1'b1, 1'b0, 1'b0, 8'd30,  16'd0,     16'hFFFF,  30,  40},
      '{1'b1, 1'b1, 1'b1, 8'd0,   16'd1000,  16'd500,   40,  30},
      '{1'b1, 1'b1, 1'b1, 8'd255, 16'd30000, 16'd50000, 200, 5}
   };

   // Every input of the block holds a known value from time zero.
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_op = '0;
   logic [19:0] req_frame_time_us = '0;
   logic [15:0] req_mem_usage_mb = '0;
   logic [1:0]  req_new_level = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_quality_level;
   logic        rsp_level_changed;
   logic        rsp_memory_warning;
   logic        rsp_memory_critical;
   logic [15:0] rsp_current_fps;
   logic [15:0] rsp_average_fps;

   // Typed expectation that travels with the item on the input channel.
   logic                probe_typed = 1'b0;
   governor_status_type probe_want = '0;

   // Idle shares of the two sides, in percent of cycles.
   int unsigned req_idle_pct = 11;
   int unsigned rsp_idle_pct = 62;

   governor_status_type status_due [$];
   int unsigned         mismatch_count = 0;
   int                  quiet_cycles = 0;

   // Register copies, holding their reset values.
   logic        cfg_auto_scale = 1'b1;
   logic        cfg_rate_maint = 1'b1;
   logic        cfg_mem_mgmt   = 1'b1;
   logic [7:0]  cfg_target     = 8'd60;
   logic [15:0] cfg_warn       = 16'd512;
   logic [15:0] cfg_crit       = 16'd1024;

   // Predicted state of the governor, holding its reset values. The window entries are
   // only read once every entry has been written, so they need no reset.
   logic [15:0] rate_hist [WINDOW];
   int unsigned hist_sum    = 0;
   int unsigned hist_count  = 0;
   int unsigned hist_ptr    = 0;
   logic [15:0] fps_latest  = '0;
   int unsigned low_frames  = 0;
   int unsigned good_frames = 0;
   logic [1:0]  gov_level   = LEVEL_HIGH;
   int unsigned mem_tick    = 0;
   logic        warn_q      = 1'b0;
   logic        crit_q      = 1'b0;

   frame_rate_quality_governor u_dut (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_op              (req_op),
      .req_frame_time_us   (req_frame_time_us),
      .req_mem_usage_mb    (req_mem_usage_mb),
      .req_new_level       (req_new_level),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_quality_level   (rsp_quality_level),
      .rsp_level_changed   (rsp_level_changed),
      .rsp_memory_warning  (rsp_memory_warning),
      .rsp_memory_critical (rsp_memory_critical),
      .rsp_current_fps     (rsp_current_fps),
      .rsp_average_fps     (rsp_average_fps)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // The window mean in 8.8 fixed point, truncated, and zero while the window is empty.
   function automatic logic [15:0] window_mean();
      if (hist_count == 0) return 16'd0;
      return 16'(hist_sum / hist_count);
   endfunction

   // A memory check does nothing while memory management is off. The critical test is
   // made first, so it wins even when its threshold lies below the warning threshold.
   function automatic void check_memory(input logic [15:0] mb);
      if (!cfg_mem_mgmt) return;
      if (mb >= cfg_crit) begin
         crit_q    = 1'b1;
         warn_q    = 1'b1;
         gov_level = LEVEL_LOW;
      end else if (mb >= cfg_warn) begin
         warn_q = 1'b1;
         crit_q = 1'b0;
      end else begin
         warn_q = 1'b0;
         crit_q = 1'b0;
      end
   endfunction

   // Moves the predicted governor on by one item and returns the status it reports.
   function automatic governor_status_type advance_governor(input logic [1:0] op,
                                                            input logic [19:0] ft,
                                                            input logic [15:0] mb,
                                                            input logic [1:0] nl);
      logic [1:0]          level_was;
      int unsigned         rate;
      int unsigned         mean10;
      int unsigned         goal;
      governor_status_type st;
      level_was = gov_level;
      case (op)
         OP_FRAME: begin
            // The sample goes into the window first; a zero time gives no sample.
            if (ft != '0) begin
               rate = FPS_DIVIDEND / {12'd0, ft};
               if (rate > 65535) rate = 65535;
               fps_latest = 16'(rate);
               if (hist_count >= WINDOW) hist_sum = hist_sum - rate_hist[hist_ptr];
               else hist_count = hist_count + 1;
               rate_hist[hist_ptr] = 16'(rate);
               hist_sum = hist_sum + rate;
               hist_ptr = (hist_ptr + 1 == WINDOW) ? 0 : hist_ptr + 1;
            end
            // The rate check runs even without a sample. An empty window counts as low unless
            // the target is zero; with a zero target every nonzero mean counts as good.
            if (cfg_rate_maint && cfg_auto_scale) begin
               mean10 = 32'(window_mean()) * 10;
               goal   = 32'(cfg_target) * 256;
               if (mean10 < goal * 9) begin
                  if (low_frames < RUN_CAP) low_frames = low_frames + 1;
                  good_frames = 0;
                  if (low_frames >= DOWN_FRAMES && gov_level != LEVEL_LOW) begin
                     gov_level  = gov_level - 2'd1;
                     low_frames = 0;
                  end
               end else if (mean10 > goal * 12) begin
                  if (good_frames < RUN_CAP) good_frames = good_frames + 1;
                  low_frames = 0;
                  if (good_frames >= UP_FRAMES && gov_level != LEVEL_ULTRA) begin
                     gov_level   = gov_level + 2'd1;
                     good_frames = 0;
                  end
               end else begin
                  low_frames  = 0;
                  good_frames = 0;
               end
            end
            // The memory period steps on every frame item, enabled or not.
            mem_tick = mem_tick + 1;
            if (mem_tick >= MEM_PERIOD) begin
               mem_tick = 0;
               check_memory(mb);
            end
         end
         OP_SET_LEVEL: begin
            gov_level   = nl;
            low_frames  = 0;
            good_frames = 0;
         end
         OP_MEM_CHECK: check_memory(mb);
         default: ;
      endcase
      st.level   = gov_level;
      st.changed = (gov_level != level_was);
      st.warn    = warn_q;
      st.crit    = crit_q;
      st.fps     = fps_latest;
      st.avg_fps = window_mean();
      return st;
   endfunction

   function automatic void check_field(input string label, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d actual %0d", $time, label, want, got);
         mismatch_count = mismatch_count + 1;
      end
   endfunction

   // Memory figures cluster on the thresholds, with both ends of the range thrown in.
   function automatic logic [15:0] pick_mem();
      case ($urandom_range(7))
         0: return cfg_warn - 16'd1;
         1: return cfg_warn;
         2: return cfg_crit - 16'd1;
         3: return cfg_crit;
         4: return 16'hFFFF;
         5: return 16'd0;
         default: return 16'($urandom);
      endcase
   endfunction

   // The receiver stalls at random, at the share of the current phase.
   always @(negedge clock) rsp_stall <= ($urandom_range(99) < rsp_idle_pct);

   // Prediction on every accepted item and checking of every accepted result. The
   // watchdog counter is cleared whenever anything moves.
   always @(posedge clock) begin
      governor_status_type want;
      governor_status_type got;
      logic                moved;
      if (!reset) begin
         moved = csr_we;
         if (req_valid && !req_stall) begin
            want = advance_governor(req_op, req_frame_time_us, req_mem_usage_mb,
                                    req_new_level);
            if (probe_typed) want = probe_want;
            status_due = {status_due, want};
            moved = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_quality_level, rsp_level_changed, rsp_memory_warning,
                    rsp_memory_critical, rsp_current_fps, rsp_average_fps};
            moved = 1'b1;
            if (status_due.size() == 0) begin
               $display("%0t: result with no item outstanding: expected none, actual %h",
                        $time, got);
               mismatch_count = mismatch_count + 1;
            end else begin
               want = status_due.pop_front();
               check_field("quality_level", want.level, got.level);
               check_field("level_changed", want.changed, got.changed);
               check_field("memory_warning", want.warn, got.warn);
               check_field("memory_critical", want.crit, got.crit);
               check_field("current_fps", want.fps, got.fps);
               check_field("average_fps", want.avg_fps, got.avg_fps);
            end
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
      end
   end

   initial begin : watchdog
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("[frame_rate_quality_governor] ERROR");
      $finish;
   end

   // Offers one item and returns at the falling edge after it has been taken. Now and
   // then the sender holds back until every outstanding result has arrived.
   task automatic send_item(input logic [1:0] op, input logic [19:0] ft,
                            input logic [15:0] mb, input logic [1:0] nl,
                            input logic typed, input governor_status_type want);
      if ($urandom_range(99) < 2) begin
         req_valid <= 1'b0;
         do @(negedge clock); while (status_due.size() != 0);
      end
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_op            <= op;
      req_frame_time_us <= ft;
      req_mem_usage_mb  <= mb;
      req_new_level     <= nl;
      probe_typed       <= typed;
      probe_want        <= want;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Waits until every result is in and the block has had time to finish its work.
   task automatic settle();
      req_valid <= 1'b0;
      do @(negedge clock); while (status_due.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Writes one register; the copy is updated once the write edge has passed.
   task automatic write_csr(input logic [2:0] index, input logic [15:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      case (index)
         CSR_AUTO_SCALE: cfg_auto_scale = value[0];
         CSR_RATE_MAINT: cfg_rate_maint = value[0];
         CSR_MEM_MGMT:   cfg_mem_mgmt   = value[0];
         CSR_TARGET_FPS: cfg_target     = value[7:0];
         CSR_MEM_WARN:   cfg_warn       = value;
         CSR_MEM_CRIT:   cfg_crit       = value;
         default: ;
      endcase
   endtask

   initial begin : stimulus
      phase_row_type  ph;
      frame_pace_type pace;
      logic           noisy;
      logic [1:0]     op;
      logic [19:0]    ft;
      logic [1:0]     nl;
      int unsigned    left;
      int unsigned    span;
      int unsigned    near;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed probes run on the reset settings.
      foreach (PROBES[i])
         send_item(PROBES[i].op, PROBES[i].ft, PROBES[i].mb, PROBES[i].nl,
                   PROBES[i].typed, PROBES[i].want);

      for (int p = 0; p < PHASE_COUNT; p++) begin
         ph = PHASES[p];
         settle();
         write_csr(CSR_AUTO_SCALE, {15'd0, ph.en_scale});
         write_csr(CSR_RATE_MAINT, {15'd0, ph.en_rate});
         write_csr(CSR_MEM_MGMT, {15'd0, ph.en_mem});
         write_csr(CSR_TARGET_FPS, {8'd0, ph.target});
         write_csr(CSR_MEM_WARN, ph.warn);
         write_csr(CSR_MEM_CRIT, ph.crit);
         csr_we <= 1'b0;

         // The receiver is the quiet side first, then the sender, then neither idles.
         if (p < 2) begin
            req_idle_pct = 11;
            rsp_idle_pct = 62;
         end else if (p < 4) begin
            req_idle_pct = 62;
            rsp_idle_pct = 11;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end

         near = (ph.target == 0) ? 0 : 1000000 / ph.target;
         left = ph.items;
         // Mostly long runs of frame items at a steady pace, so that the run counters
         // reach their thresholds; short bursts of mixed items in between.
         while (left > 0) begin
            noisy = ($urandom_range(99) < ph.noise_pct);
            pace  = frame_pace_type'($urandom_range(3));
            span  = noisy ? $urandom_range(10, 3) : $urandom_range(60, 20);
            for (int k = 0; k < span && left > 0; k++) begin
               nl = 2'($urandom);
               if (noisy) begin
                  op = 2'($urandom);
                  ft = 20'($urandom);
               end else begin
                  op = OP_FRAME;
                  case (pace)
                     PACE_SLOW: ft = 20'($urandom_range(200000, 20000));
                     PACE_FAST: ft = 20'($urandom_range(15000, 1));
                     PACE_WIDE: ft = 20'($urandom);
                     default:   ft = (near == 0) ? 20'($urandom)
                                                 : 20'(near * $urandom_range(125, 80) / 100);
                  endcase
                  if ($urandom_range(19) == 0) ft = '0;
               end
               send_item(op, ft, pick_mem(), nl, 1'b0, '0);
               left = left - 1;
            end
         end
      end

      settle();
      if (mismatch_count == 0 && status_due.size() == 0)
         $display("[frame_rate_quality_governor] OK");
      else
         $display("[frame_rate_quality_governor] ERROR");
      $finish;
   end

endmodule
